// File: sv/fbfl_pkg.sv
// Shared types and constants for the fixed-block free-list allocator.
// Used by fbfl_link_ram and fixed_block_free_list_allocator; no dependencies.
package fbfl_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = 11;
  localparam int LOG2_W     = 5;
  localparam int OFS_W      = 26;
  localparam int SIZE_W     = 17;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(16);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REALLOC = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_SIZE   = 3'd2,
    STAT_RANGE  = 3'd3,
    STAT_ALIGN  = 3'd4,
    STAT_TOOBIG = 3'd5
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITEM_SIZE_LOG2 = 1'd0,
    CFG_ITEM_COUNT     = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One link table entry: next free block and whether it exists
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    link_t            wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: sv/fbfl_link_ram.sv
// Link table storage: one write port, one read port, registered read data.
// Depends on fbfl_pkg.
module fbfl_link_ram (
  input  logic             clk,
  input  fbfl_pkg::ram_req_t req,
  output fbfl_pkg::link_t  rdata
);
  import fbfl_pkg::*;

  link_t mem [POOL_DEPTH];
  link_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fixed_block_free_list_allocator.sv
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg and fbfl_link_ram.
//
// Usage:
//   in_*  : request words. in_tuser = req_type (0 alloc, 1 free, 2 realloc).
//           in_tdata = block_offset, request_size from bit 0 up.
//   out_* : one result word per request. out_tdata = result_offset,
//           out_tuser = status.
//   cfg_* : register writes, index 0 item_size_log2, index 1 item_count.
//           Always ready. Writing item_count rethreads the free list.
// Request flow:
//   A request is accepted in ST_IDLE while the link table RAM reads the
//   head's link entry; in ST_EXEC the block updates head and table and loads
//   the output register. No new request is accepted until ST_EXEC ends.
// Reset and rethreading:
//   After reset, and after each item_count write, a sweep over all 1024 link
//   table entries writes the threaded list into the table; in_tready stays low.
// Back-pressure:
//   The result waits in the output register; the next request may be
//   accepted meanwhile, and is held in execution until the register frees.
module fixed_block_free_list_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fbfl_pkg::IN_DATA_W-1:0]       in_tdata,  // block_offset, request_size
  input  logic [fbfl_pkg::REQ_W-1:0]           in_tuser,  // req_type
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fbfl_pkg::OUT_DATA_W-1:0]      out_tdata, // result_offset
  output logic [fbfl_pkg::STAT_W-1:0]          out_tuser, // status
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbfl_pkg::CNT_W-1:0]           cfg_data
);
  import fbfl_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   swp_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               head_vld_r, head_vld_nxt;
  logic [LOG2_W-1:0]  lg_r;
  logic [CNT_W-1:0]   cnt_r;

  req_t               req_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [SIZE_W-1:0]  size_r;

  logic               out_vld_r;
  logic [OFS_W-1:0]   out_ofs_r, out_ofs_nxt;
  stat_t              out_st_r, out_st_nxt;

  ram_req_t           ram_req;
  link_t              rd_link;

  logic               cfg_wr, cnt_wr;
  logic               in_acc, exec_done, sweep_last;
  logic [LOG2_W-1:0]  lg_eff;
  logic [CNT_W-1:0]   n_eff;
  logic [SIZE_W-1:0]  bsize;
  logic [OFS_W:0]     pool_end;
  logic [CNT_W-1:0]   swp_succ;
  logic               swp_link_vld;
  logic [IDX_W-1:0]   free_idx;
  logic               do_free;

  fbfl_link_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rd_link)
  );

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid & cfg_ready;
  assign cnt_wr     = cfg_wr && (cfg_index == CFG_ITEM_COUNT);
  assign in_acc     = in_tvalid & in_tready;
  assign exec_done  = (state_r == ST_EXEC) && (!out_vld_r || out_tready);
  assign sweep_last = (swp_r == IDX_W'(POOL_DEPTH - 1));

  assign lg_eff   = (lg_r > LOG2_MAX) ? LOG2_MAX : lg_r;
  assign n_eff    = (cnt_r == '0) ? CNT_W'(1) :
                    (cnt_r > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : cnt_r;
  assign bsize    = SIZE_W'(1) << lg_eff;
  assign pool_end = (OFS_W+1)'(n_eff) << lg_eff;
  assign free_idx = IDX_W'(ofs_r >> lg_eff);

  assign swp_succ     = CNT_W'(swp_r) + CNT_W'(1);
  assign swp_link_vld = (swp_succ < n_eff);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_SWEEP;
    endcase
    if (cnt_wr) state_nxt = ST_SWEEP;
  end

  // Request evaluation and RAM port
  always_comb begin
    out_ofs_nxt  = '0;
    out_st_nxt   = STAT_OK;
    head_nxt     = head_r;
    head_vld_nxt = head_vld_r;
    do_free      = 1'b0;
    case (req_r)
      REQ_ALLOC: begin
        if (size_r != bsize) begin
          out_st_nxt = STAT_SIZE;
        end else if (!head_vld_r) begin
          out_st_nxt = STAT_EMPTY;
        end else begin
          out_ofs_nxt  = OFS_W'(head_r) << lg_eff;
          head_nxt     = rd_link.next;
          head_vld_nxt = rd_link.valid;
        end
      end
      REQ_FREE: begin
        if ({1'b0, ofs_r} >= pool_end) begin
          out_st_nxt = STAT_RANGE;
        end else if ((ofs_r & OFS_W'(bsize - SIZE_W'(1))) != '0) begin
          out_st_nxt = STAT_ALIGN;
        end else begin
          do_free      = 1'b1;
          head_nxt     = free_idx;
          head_vld_nxt = 1'b1;
        end
      end
      REQ_REALLOC: begin
        if (size_r <= bsize) begin
          out_ofs_nxt = ofs_r;
        end else begin
          out_st_nxt = STAT_TOOBIG;
        end
      end
      default: begin
        out_st_nxt = STAT_OK;
      end
    endcase

    ram_req.raddr = head_r;
    if (state_r == ST_SWEEP) begin
      ram_req.we          = 1'b1;
      ram_req.waddr       = swp_r;
      ram_req.wdata.valid = swp_link_vld;
      ram_req.wdata.next  = swp_link_vld ? swp_succ[IDX_W-1:0] : '0;
    end else begin
      ram_req.we          = exec_done & do_free;
      ram_req.waddr       = free_idx;
      ram_req.wdata.valid = head_vld_r;
      ram_req.wdata.next  = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      swp_r      <= '0;
      head_r     <= '0;
      head_vld_r <= 1'b1;
      lg_r       <= LOG2_W'(4);
      cnt_r      <= CNT_W'(POOL_DEPTH);
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (cfg_index == CFG_ITEM_SIZE_LOG2)) lg_r <= cfg_data[LOG2_W-1:0];
      if (cnt_wr) begin
        cnt_r      <= cfg_data;
        swp_r      <= '0;
        head_r     <= '0;
        head_vld_r <= 1'b1;
      end else begin
        if (state_r == ST_SWEEP) swp_r <= swp_r + IDX_W'(1);
        if (exec_done) begin
          head_r     <= head_nxt;
          head_vld_r <= head_vld_nxt;
        end
      end
      if (exec_done) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= req_t'(in_tuser);
      ofs_r  <= in_tdata[OFS_W-1:0];
      size_r <= in_tdata[OFS_W +: SIZE_W];
    end
    if (exec_done) begin
      out_ofs_r <= out_ofs_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_ofs_r);
  assign out_tuser  = out_st_r;

endmodule

// File: verif/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for fixed_block_free_list_allocator: directed rows, then random
// phases over several pool shapes, checked against fixed expected values or an in-bench free-list predictor.
// Depends on fbfl_pkg and the allocator RTL only.
module fixed_block_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbfl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 10;
  localparam int          PHASE_WORDS = 140;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    stat_t            st;
  } reply_t;

  typedef struct packed {
    bit                is_cfg;
    cfg_reg_t          sel;
    logic [CNT_W-1:0]  val;
    req_t              req;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
    bit                fixed;
    reply_t            want;
  } step_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CNT_W-1:0]      cfg_data   = '0;

  // predicted allocator state
  logic [LOG2_W-1:0] size_log2_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  head_idx;
  logic              head_live;
  logic [IDX_W-1:0]  next_idx  [POOL_DEPTH];
  logic              next_live [POOL_DEPTH];

  reply_t            replies_due[$];
  logic [OFS_W-1:0]  held[$];
  step_t             plan[$];
  bit                tx_calm    = 1'b0;
  bit                rx_calm    = 1'b0;
  int unsigned       rx_hold    = 0;
  int unsigned       n_bad      = 0;
  int unsigned       n_cycles   = 0;

  fixed_block_free_list_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // block_offset, request_size
    .in_tuser   (in_tuser),   // req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // result_offset
    .out_tuser  (out_tuser),  // status
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  function automatic int unsigned eff_log2();
    return (size_log2_q > LOG2_MAX) ? int'(LOG2_MAX) : int'(size_log2_q);
  endfunction

  function automatic int unsigned eff_count();
    if (count_q == 0) return 1;
    if (count_q > POOL_DEPTH) return POOL_DEPTH;
    return 32'(count_q);
  endfunction

  function automatic void rethread_pool();
    int unsigned n;
    n = eff_count();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      next_live[i] = (i + 1 < n);
      next_idx[i]  = next_live[i] ? IDX_W'(i + 1) : '0;
    end
    head_idx  = '0;
    head_live = 1'b1;
  endfunction

  function automatic reply_t serve_request(req_t req, logic [OFS_W-1:0] ofs,
                                           logic [SIZE_W-1:0] size);
    int unsigned     lg;
    longint unsigned bsize;
    longint unsigned pool_end;
    logic [IDX_W-1:0] h;
    reply_t          r;
    lg       = eff_log2();
    bsize    = 64'd1 << lg;
    pool_end = 64'(eff_count()) << lg;
    r.ofs    = '0;
    r.st     = STAT_OK;
    case (req)
      REQ_ALLOC: begin
        if (64'(size) != bsize) r.st = STAT_SIZE;
        else if (!head_live) r.st = STAT_EMPTY;
        else begin
          h         = head_idx;
          r.ofs     = OFS_W'(64'(h) << lg);
          head_live = next_live[h];
          head_idx  = next_idx[h];
        end
      end
      REQ_FREE: begin
        if (64'(ofs) >= pool_end) r.st = STAT_RANGE;
        else if ((64'(ofs) & (bsize - 1)) != 0) r.st = STAT_ALIGN;
        else begin
          h            = IDX_W'(ofs >> lg);
          next_idx[h]  = head_idx;
          next_live[h] = head_live;
          head_idx     = h;
          head_live    = 1'b1;
        end
      end
      REQ_REALLOC: begin
        if (64'(size) <= bsize) r.ofs = ofs;
        else r.st = STAT_TOOBIG;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t cfg_row(cfg_reg_t sel, logic [CNT_W-1:0] val);
    step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.sel    = sel;
    s.val    = val;
    return s;
  endfunction

  function automatic step_t req_row(req_t req, logic [OFS_W-1:0] ofs,
                                    logic [SIZE_W-1:0] size, bit fixed,
                                    logic [OFS_W-1:0] w_ofs, stat_t w_st);
    step_t s;
    s         = '0;
    s.req     = req;
    s.ofs     = ofs;
    s.size    = size;
    s.fixed   = fixed;
    s.want.ofs = w_ofs;
    s.want.st  = w_st;
    return s;
  endfunction

  task automatic send_req(input req_t req, input logic [OFS_W-1:0] ofs,
                          input logic [SIZE_W-1:0] size, input bit fixed,
                          input reply_t want, output reply_t got);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_DATA_W'({size, ofs});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = serve_request(req, ofs, size);
    replies_due.push_back(fixed ? want : got);
  endtask

  // hold off until every result word is back and the block is ready again
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (sel == CFG_ITEM_SIZE_LOG2) size_log2_q = val[LOG2_W-1:0];
    else begin
      count_q = val;
      rethread_pool();
    end
    held.delete();
  endtask

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t      want;
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("result word with nothing outstanding: offset %h status %0d",
               out_tdata[OFS_W-1:0], out_tuser);
        n_bad++;
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[OFS_W-1:0] !== want.ofs) begin
          $error("result_offset: expected %h, got %h", want.ofs, out_tdata[OFS_W-1:0]);
          n_bad++;
        end
        if (out_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tuser);
          n_bad++;
        end
      end
      w = rx_calm ? 0 : $urandom_range(0, 18);
      out_tready <= (w == 0);
      rx_hold    <= w;
    end else if (!out_tready && rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned       p;
    int unsigned       k_sel;
    int unsigned       lgv;
    longint unsigned   bs;
    req_t              rq;
    logic [OFS_W-1:0]  ofs_v;
    logic [SIZE_W-1:0] size_v;
    logic [CNT_W-1:0]  lg_val;
    logic [CNT_W-1:0]  cnt_val;
    bit                do_cnt;
    reply_t            got;
    reply_t            none_r;

    none_r      = '0;
    size_log2_q = LOG2_W'(4);
    count_q     = CNT_W'(POOL_DEPTH);
    rethread_pool();

    plan = '{
      req_row(REQ_ALLOC,   '0,          17'd16,      1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'd0,       1, '0,          STAT_SIZE),
      req_row(REQ_ALLOC,   26'h3FFFFFF, 17'h1FFFF,   1, '0,          STAT_SIZE),
      req_row(REQ_FREE,    26'h3FFFFFF, 17'd16,      1, '0,          STAT_RANGE),
      req_row(REQ_FREE,    26'd16384,   17'd0,       1, '0,          STAT_RANGE),
      req_row(REQ_FREE,    26'd16383,   17'd0,       1, '0,          STAT_ALIGN),
      req_row(REQ_FREE,    26'd0,       17'd0,       1, '0,          STAT_OK),
      req_row(REQ_FREE,    26'd0,       17'h1FFFF,   1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'd16,      0, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'd16,      0, '0,          STAT_OK),
      req_row(REQ_REALLOC, 26'h3FFFFFF, 17'd16,      1, 26'h3FFFFFF, STAT_OK),
      req_row(REQ_REALLOC, 26'h155,     17'd17,      1, '0,          STAT_TOOBIG),
      req_row(REQ_REALLOC, 26'h2AAAAAA, 17'd0,       1, 26'h2AAAAAA, STAT_OK),
      req_row(REQ_NONE,    26'h3FFFFFF, 17'h1FFFF,   1, '0,          STAT_OK),
      cfg_row(CFG_ITEM_COUNT, 11'd1),
      req_row(REQ_ALLOC,   '0,          17'd16,      1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'd16,      1, '0,          STAT_EMPTY),
      req_row(REQ_FREE,    26'd16,      17'd0,       1, '0,          STAT_RANGE),
      req_row(REQ_FREE,    26'd0,       17'd0,       1, '0,          STAT_OK),
      cfg_row(CFG_ITEM_COUNT, 11'd0),
      req_row(REQ_ALLOC,   '0,          17'd16,      1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'd16,      1, '0,          STAT_EMPTY),
      cfg_row(CFG_ITEM_SIZE_LOG2, 11'h7FF),
      cfg_row(CFG_ITEM_COUNT, 11'h7FF),
      req_row(REQ_ALLOC,   '0,          17'h10000,   1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'h10000,   1, 26'h10000,   STAT_OK),
      req_row(REQ_FREE,    26'h3FFFFFF, 17'd0,       1, '0,          STAT_ALIGN),
      req_row(REQ_FREE,    26'h3FF0000, 17'd0,       1, '0,          STAT_OK),
      req_row(REQ_ALLOC,   '0,          17'h10000,   0, '0,          STAT_OK),
      cfg_row(CFG_ITEM_SIZE_LOG2, 11'd0),
      req_row(REQ_ALLOC,   '0,          17'd1,       0, '0,          STAT_OK)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        send_req(plan[i].req, plan[i].ofs, plan[i].size, plan[i].fixed, plan[i].want, got);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lg_val = 11'd0;   cnt_val = 11'd1;    end
        1: begin lg_val = 11'd16;  cnt_val = 11'd1024; end
        2: begin lg_val = 11'h7FF; cnt_val = 11'h7FF;  end
        3: begin lg_val = 11'd4;   cnt_val = 11'd0;    end
        default: begin
          lg_val = CNT_W'($urandom_range(0, 31));
          if ($urandom_range(0, 1) == 1) begin
            lg_val[CNT_W-1:LOG2_W] = (CNT_W-LOG2_W)'($urandom);
          end
          case ($urandom_range(0, 4))
            0:       cnt_val = CNT_W'($urandom_range(2, 8));
            1:       cnt_val = CNT_W'(POOL_DEPTH);
            2:       cnt_val = CNT_W'($urandom_range(POOL_DEPTH + 1, 2047));
            default: cnt_val = CNT_W'($urandom_range(2, 64));
          endcase
        end
      endcase
      do_cnt = (ph < 4) || ($urandom_range(0, 1) == 1);
      settle();
      write_reg(CFG_ITEM_SIZE_LOG2, lg_val);
      if (do_cnt) begin
        settle();
        write_reg(CFG_ITEM_COUNT, cnt_val);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      lgv = eff_log2();
      bs  = 64'd1 << lgv;

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k == PHASE_WORDS / 2) settle();
        p      = $urandom_range(0, 99);
        ofs_v  = OFS_W'($urandom);
        size_v = SIZE_W'($urandom);
        if (p < 40) begin
          rq     = REQ_ALLOC;
          size_v = SIZE_W'(bs);
        end else if (p < 45) begin
          rq = REQ_ALLOC;
        end else if (p < 72) begin
          rq = REQ_FREE;
          if (held.size() != 0 && $urandom_range(0, 3) != 0) begin
            k_sel = $urandom_range(0, held.size() - 1);
            ofs_v = held[k_sel];
            held.delete(k_sel);
          end else begin
            ofs_v = OFS_W'(64'($urandom_range(0, eff_count() - 1)) << lgv);
          end
        end else if (p < 80) begin
          rq = REQ_FREE;
          if (p < 76) ofs_v = OFS_W'((64'(eff_count()) << lgv) - $urandom_range(1, 3));
        end else if (p < 95) begin
          rq = REQ_REALLOC;
          if (p < 88) size_v = SIZE_W'($urandom_range(0, 32'(bs)));
        end else begin
          rq = REQ_NONE;
        end
        send_req(rq, ofs_v, size_v, 1'b0, none_r, got);
        if (rq == REQ_ALLOC && got.st == STAT_OK) held.push_back(got.ofs);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (n_bad == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
